### hw/rtl/lfsa_pkg.sv
// ---------------------------------------------------------------------------
// lfsa_pkg
// Shared constants and the word type that moves along the seat chain.
// ---------------------------------------------------------------------------
package lfsa_pkg;

   localparam int SEATS     = 64;
   localparam int TIME_BITS = 32;
   localparam int IN_W      = 32;
   localparam int USE_W     = 16;
   localparam int OUT_W     = 7;
   localparam int CNT_W     = $clog2(SEATS + 1);

   localparam logic [USE_W-1:0] USE_MAX = {USE_W{1'b1}};

   typedef struct packed {
      logic                 valid;
      logic [TIME_BITS-1:0] start;
      logic [TIME_BITS-1:0] stop;
      logic                 claimed;
      logic [CNT_W-1:0]     seat;
      logic [USE_W-1:0]     uses;
      logic [CNT_W-1:0]     open_cnt;
   } word_type;

endpackage

### hw/rtl/lfsa_cell.sv
// ---------------------------------------------------------------------------
// lfsa_cell
// One seat: holds busy-until time, use count and open flag, and claims the
// passing word if it is still unplaced and this seat is free or unopened.
// ---------------------------------------------------------------------------
module lfsa_cell
   import lfsa_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic [CNT_W-1:0] cell_num,
   input  word_type         word_i,
   output word_type         word_o,
   output logic             opened
);

   logic                 open_ff, open_in;
   logic [TIME_BITS-1:0] busy_ff, busy_in;
   logic [USE_W-1:0]     uses_ff, uses_in;
   word_type             word_ff, word_in;
   logic                 hit;

   assign hit = word_i.valid && !word_i.claimed && (!open_ff || busy_ff <= word_i.start);

   always_comb begin
      open_in = open_ff;
      busy_in = busy_ff;
      uses_in = uses_ff;
      if (hit) begin
         open_in = 1'b1;
         busy_in = word_i.stop;
         uses_in = (uses_ff == USE_MAX) ? uses_ff : uses_ff + USE_W'(1);
      end
   end

   always_comb begin
      word_in         = word_i;
      word_in.claimed = word_i.claimed || hit;
      if (hit) begin
         word_in.seat = cell_num;
         word_in.uses = uses_in;
      end
      word_in.open_cnt = word_i.open_cnt + CNT_W'(open_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff       <= 1'b0;
         uses_ff       <= '0;
         word_ff.valid <= 1'b0;
      end else if (advance) begin
         open_ff       <= open_in;
         uses_ff       <= uses_in;
         word_ff.valid <= word_in.valid;
      end
      // payload needs no reset; busy time is only read once the seat is open
      if (advance) begin
         busy_ff          <= busy_in;
         word_ff.start    <= word_in.start;
         word_ff.stop     <= word_in.stop;
         word_ff.claimed  <= word_in.claimed;
         word_ff.seat     <= word_in.seat;
         word_ff.uses     <= word_in.uses;
         word_ff.open_cnt <= word_in.open_cnt;
      end
   end

   assign word_o = word_ff;
   assign opened = open_ff;

endmodule

### hw/rtl/lowest_free_seat_allocator_top.sv
// ---------------------------------------------------------------------------
// lowest_free_seat_allocator_top
// Places booking intervals on the lowest-numbered free seat.
// ---------------------------------------------------------------------------
// Usage:
//   req_ channel takes one interval word (start_time, end_time) per accept;
//   starts are expected in nondecreasing order. rsp_ channel returns one word
//   per request: seat (from 1), its updated use count, seats opened so far,
//   and full_res when no seat was free and none was left to open.
//   The word travels down a chain of SEATS seat cells, one cell per cycle
//   unless the chain is frozen; each cell checks and updates its own seat,
//   so a new word can enter every cycle while the chain is not frozen.
//   rsp_valid and the result are driven from the last cell's register;
//   throughput one word per cycle when rsp_stall does not freeze the chain.
//   Reset closes all seats and clears all use counts; it takes effect in the
//   cycle of reset, no clearing sweep.
//   When rsp_stall holds a valid result, the whole chain freezes and
//   req_stall is raised in the same cycle until the result is taken.
// ---------------------------------------------------------------------------
module lowest_free_seat_allocator_top
   import lfsa_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [IN_W-1:0]  req_start_time,
   input  logic [IN_W-1:0]  req_end_time,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [OUT_W-1:0] rsp_seat,
   output logic [USE_W-1:0] rsp_seat_uses,
   output logic [OUT_W-1:0] rsp_seats_open,
   output logic             rsp_full_res
);

   word_type         chain [SEATS+1];
   logic [SEATS-1:0] open_vec;
   logic             advance;
   word_type         last;

   assign last    = chain[SEATS];
   assign advance = !(last.valid && rsp_stall);
   assign req_stall = !advance;

   always_comb begin
      chain[0]          = '0;
      chain[0].valid    = req_valid;
      chain[0].start    = TIME_BITS'(req_start_time);
      chain[0].stop     = TIME_BITS'(req_end_time);
   end

   for (genvar i = 0; i < SEATS; i++) begin : g_cell
      lfsa_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .cell_num (CNT_W'(i + 1)),
         .word_i   (chain[i]),
         .word_o   (chain[i+1]),
         .opened   (open_vec[i])
      );
   end

   // a word that no cell claimed means every seat was open and busy
   assign rsp_valid      = last.valid;
   assign rsp_full_res   = !last.claimed;
   assign rsp_seat       = last.claimed ? OUT_W'(last.seat) : '0;
   assign rsp_seat_uses  = last.claimed ? last.uses : '0;
   assign rsp_seats_open = OUT_W'(last.open_cnt);

   a_claim_has_seat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_full_res |-> rsp_seat != '0 && rsp_seat_uses != '0)
      else $error("claimed word without seat or use count");

   a_full_all_open: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_full_res |-> last.open_cnt == CNT_W'(SEATS))
      else $error("full reported with seats still unopened");

   a_seat_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_full_res |-> last.seat <= last.open_cnt)
      else $error("assigned seat beyond opened seats");

   a_open_prefix: assert property (@(posedge clock) disable iff (reset)
      ((open_vec + SEATS'(1)) & open_vec) == '0)
      else $error("opened seats are not a prefix");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(last.open_cnt))
      else $error("stalled result lost");

endmodule
